// File: design/assert_macros.svh
// assertion macros shared by the button event detector rtl
// no dependencies; each macro expands to one concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define BCD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("button event detector: same-cycle check failed");

// antecedent holds -> consequent holds in the next cycle
`define BCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("button event detector: next-cycle check failed");

`endif

// File: design/bcd_pkg.sv
// shared types and constants for the button event detector
// no dependencies
`default_nettype none

package bcd_pkg;

  // configuration register indexes
  localparam logic [7:0] CfgActiveLevel  = 8'd0;
  localparam logic [7:0] CfgDebounceTick = 8'd1;
  localparam logic [7:0] CfgShortTicks   = 8'd2;
  localparam logic [7:0] CfgLongTicks    = 8'd3;

  // register reset values
  localparam logic        RstActiveLevel  = 1'b0;
  localparam logic [7:0]  RstDebounceTick = 8'd3;
  localparam logic [15:0] RstShortTicks   = 16'd60;
  localparam logic [15:0] RstLongTicks    = 16'd200;

  // accepted level after reset: inverse of the reset active level
  localparam logic RstStableLevel = 1'b1;

  // press count saturation limit
  localparam logic [3:0] RepeatLimit = 4'd15;

  // bit positions in the fired event mask
  localparam int unsigned FireDown      = 0;
  localparam int unsigned FireUp        = 1;
  localparam int unsigned FireRepeat    = 2;
  localparam int unsigned FireSingle    = 3;
  localparam int unsigned FireDouble    = 4;
  localparam int unsigned FireLongStart = 5;
  localparam int unsigned FireHold      = 6;

  // latched event codes
  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_DOWN       = 3'd1,
    EV_UP         = 3'd2,
    EV_REPEAT     = 3'd3,
    EV_SINGLE     = 3'd4,
    EV_DOUBLE     = 3'd5,
    EV_LONG_START = 3'd6,
    EV_HOLD       = 3'd7
  } event_e;

  // timing limits for the press state machine
  typedef struct packed {
    logic [15:0] click_limit;
    logic [15:0] hold_limit;
  } press_cfg_t;

  // per-tick result of the press state machine
  typedef struct packed {
    logic [6:0] fired;
    event_e     last_event;
    logic [3:0] repeats;
  } press_res_t;

endpackage

`default_nettype wire

// File: design/button_click_event_detector_unit.sv
// Button click event detector: debounces one button pin and reports down,
// up, repeat, single, double, long start and long hold events.
// Depends on bcd_pkg, bcd_debounce, bcd_press_fsm and assert_macros.svh.
//
// Channels: each input transfer (in_valid_i/in_ready_o) carries one tick
// with the raw pin level. Each tick yields exactly one result transfer
// (out_valid_o/out_ready_i) with the fired event mask, latched event,
// press count and debounced level. Configuration writes arrive on
// cfg_valid_i/cfg_ready_o with a register index and data; cfg_ready_o is
// always high, indexes past the last register are dropped. Write only
// while no tick is in flight.
// Path: the tick is captured in an input register at its transfer; its
// result is computed and stored in the output register once the result
// slot is free, and is shown from there.
// Throughput: one tick per cycle while out_ready_i stays high; the
// debouncer and press state machine update between the two registers.
// Reset: all state goes idle, configuration registers take their reset
// values and the debouncer's accepted level reads as released (high).
// Stall: while out_ready_i is low the result holds; one more tick can
// wait in the input register, after which in_ready_o drops.
`default_nettype none

`include "assert_macros.svh"

module button_click_event_detector_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  // tick input channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        pin_level_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [6:0]       fired_events_o,
  output logic [2:0]       current_event_o,
  output logic [3:0]       repeat_count_o,
  output logic             debounced_level_o
);

  logic                active_level_q;
  logic [7:0]          debounce_ticks_q;
  bcd_pkg::press_cfg_t press_cfg_q;

  logic                s1_valid_q;
  logic                s1_pin_q;
  logic                step;

  logic                level_d;
  logic                level_q;
  bcd_pkg::press_res_t res;

  logic                out_valid_q;
  logic [6:0]          fired_q;
  logic [2:0]          event_q;
  logic [3:0]          reps_q;
  logic                level_out_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_level_q          <= bcd_pkg::RstActiveLevel;
      debounce_ticks_q        <= bcd_pkg::RstDebounceTick;
      press_cfg_q.click_limit <= bcd_pkg::RstShortTicks;
      press_cfg_q.hold_limit  <= bcd_pkg::RstLongTicks;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bcd_pkg::CfgActiveLevel:  active_level_q          <= cfg_data_i[0];
        bcd_pkg::CfgDebounceTick: debounce_ticks_q        <= cfg_data_i[7:0];
        bcd_pkg::CfgShortTicks:   press_cfg_q.click_limit <= cfg_data_i;
        bcd_pkg::CfgLongTicks:    press_cfg_q.hold_limit  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake: a tick moves to the output when the result slot is free
  assign step       = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || step;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_pin_q <= pin_level_i;
    end
  end

  bcd_debounce u_debounce (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .pin_level_i      (s1_pin_q),
    .debounce_ticks_i (debounce_ticks_q),
    .level_d_o        (level_d),
    .level_q_o        (level_q)
  );

  bcd_press_fsm u_press_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .pressed_i (level_d == active_level_q),
    .cfg_i     (press_cfg_q),
    .res_o     (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      fired_q     <= res.fired;
      event_q     <= res.last_event;
      reps_q      <= res.repeats;
      level_out_q <= level_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign fired_events_o    = fired_q;
  assign current_event_o   = event_q;
  assign repeat_count_o    = reps_q;
  assign debounced_level_o = level_out_q;

  // checks
  `BCD_ASSERT_NEXT(a_step_fills_out, clk_i, rst_ni, step, out_valid_q)
  `BCD_ASSERT_SAME(a_repeat_with_down, clk_i, rst_ni,
    out_valid_q && fired_q[bcd_pkg::FireRepeat], fired_q[bcd_pkg::FireDown])
  `BCD_ASSERT_SAME(a_down_has_count, clk_i, rst_ni,
    out_valid_q && fired_q[bcd_pkg::FireDown], reps_q != 4'd0)
  `BCD_ASSERT_NEXT(a_level_tracks, clk_i, rst_ni, step, level_q == level_out_q)

endmodule

`default_nettype wire

// File: design/bcd_debounce.sv
// pin debouncer: counts ticks a changed level persists, then takes it
// depends on bcd_pkg
`default_nettype none

module bcd_debounce (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic       pin_level_i,
  input  wire logic [7:0] debounce_ticks_i,
  output logic            level_d_o,
  output logic            level_q_o
);

  logic       stable_q, stable_d;
  logic [7:0] count_q, count_d;
  logic [7:0] count_inc;

  // next accepted level and persistence count
  always_comb begin
    count_inc = count_q + 8'd1;
    stable_d  = stable_q;
    count_d   = 8'd0;
    if (pin_level_i != stable_q) begin
      if (count_inc >= debounce_ticks_i) begin
        stable_d = pin_level_i;
      end else begin
        count_d = count_inc;
      end
    end
  end

  // state advances once per tick transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= bcd_pkg::RstStableLevel;
      count_q  <= 8'd0;
    end else if (step_i) begin
      stable_q <= stable_d;
      count_q  <= count_d;
    end
  end

  assign level_d_o = stable_d;
  assign level_q_o = stable_q;

endmodule

`default_nettype wire

// File: design/bcd_press_fsm.sv
// press state machine: click, multi-click and long press detection
// depends on bcd_pkg
`default_nettype none

module bcd_press_fsm (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire logic                pressed_i,
  input  wire bcd_pkg::press_cfg_t cfg_i,
  output bcd_pkg::press_res_t      res_o
);

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_PRESSED  = 3'd1,
    ST_WAITING  = 3'd2,
    ST_REPRESS  = 3'd3,
    ST_LONG     = 3'd5
  } state_e;

  state_e          state_q, state_d;
  logic [15:0]     tick_q, tick_d, tick_adv;
  logic [3:0]      reps_q, reps_d;
  bcd_pkg::event_e ev_q, ev_d;
  logic [6:0]      fired;

  // next state, timer, press count and events
  always_comb begin
    tick_adv = (state_q != ST_IDLE) ? tick_q + 16'd1 : tick_q;
    tick_d   = tick_adv;
    state_d  = state_q;
    reps_d   = reps_q;
    ev_d     = ev_q;
    fired    = '0;
    case (state_q)
      ST_IDLE: begin
        if (pressed_i) begin
          ev_d                      = bcd_pkg::EV_DOWN;
          fired[bcd_pkg::FireDown] = 1'b1;
          tick_d                    = 16'd0;
          reps_d                    = 4'd1;
          state_d                   = ST_PRESSED;
        end else begin
          ev_d = bcd_pkg::EV_NONE;
        end
      end
      ST_PRESSED: begin
        if (!pressed_i) begin
          ev_d                    = bcd_pkg::EV_UP;
          fired[bcd_pkg::FireUp] = 1'b1;
          tick_d                  = 16'd0;
          state_d                 = ST_WAITING;
        end else if (tick_adv > cfg_i.hold_limit) begin
          ev_d                           = bcd_pkg::EV_LONG_START;
          fired[bcd_pkg::FireLongStart] = 1'b1;
          state_d                        = ST_LONG;
        end
      end
      ST_WAITING: begin
        if (pressed_i) begin
          // further press: down and repeat together, latched as down
          ev_d                        = bcd_pkg::EV_DOWN;
          fired[bcd_pkg::FireDown]   = 1'b1;
          fired[bcd_pkg::FireRepeat] = 1'b1;
          if (reps_q != bcd_pkg::RepeatLimit) begin
            reps_d = reps_q + 4'd1;
          end
          tick_d  = 16'd0;
          state_d = ST_REPRESS;
        end else if (tick_adv > cfg_i.click_limit) begin
          // three or more clicks end silently
          if (reps_q == 4'd1) begin
            ev_d                        = bcd_pkg::EV_SINGLE;
            fired[bcd_pkg::FireSingle] = 1'b1;
          end else if (reps_q == 4'd2) begin
            ev_d                        = bcd_pkg::EV_DOUBLE;
            fired[bcd_pkg::FireDouble] = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      ST_REPRESS: begin
        if (!pressed_i) begin
          ev_d                    = bcd_pkg::EV_UP;
          fired[bcd_pkg::FireUp] = 1'b1;
          if (tick_adv < cfg_i.click_limit) begin
            tick_d  = 16'd0;
            state_d = ST_WAITING;
          end else begin
            state_d = ST_IDLE;
          end
        end else if (tick_adv > cfg_i.click_limit) begin
          state_d = ST_PRESSED;
        end
      end
      ST_LONG: begin
        if (pressed_i) begin
          ev_d                      = bcd_pkg::EV_HOLD;
          fired[bcd_pkg::FireHold] = 1'b1;
        end else begin
          ev_d                    = bcd_pkg::EV_UP;
          fired[bcd_pkg::FireUp] = 1'b1;
          state_d                 = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state advances once per tick transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tick_q  <= 16'd0;
      reps_q  <= 4'd0;
      ev_q    <= bcd_pkg::EV_NONE;
    end else if (step_i) begin
      state_q <= state_d;
      tick_q  <= tick_d;
      reps_q  <= reps_d;
      ev_q    <= ev_d;
    end
  end

  assign res_o.fired      = fired;
  assign res_o.last_event = ev_d;
  assign res_o.repeats    = reps_d;

endmodule

`default_nettype wire

// File: dv/button_click_event_detector_unit_tb.sv
// testbench for the button click event detector unit: drives pin ticks and
// register writes, and checks every result against an in-bench predictor
// depends on bcd_pkg and button_click_event_detector_unit
module button_click_event_detector_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // press state machine codes
  typedef enum logic [2:0] {
    PS_IDLE    = 3'd0,
    PS_PRESSED = 3'd1,
    PS_WAIT    = 3'd2,
    PS_REPEAT  = 3'd3,
    PS_LONG    = 3'd5
  } press_state_e;

  // one tick's worth of result fields
  typedef struct packed {
    logic [6:0]      fired;
    bcd_pkg::event_e evt;
    logic [3:0]      presses;
    logic            level;
  } tick_result_t;

  logic        clk_i;
  logic        rst_ni            = 1'b0;
  logic        cfg_valid_i       = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i       = '0;
  logic [15:0] cfg_data_i        = '0;
  logic        in_valid_i        = 1'b0;
  logic        in_ready_o;
  logic        pin_level_i       = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i       = 1'b0;
  logic [6:0]  fired_events_o;
  logic [2:0]  current_event_o;
  logic [3:0]  repeat_count_o;
  logic        debounced_level_o;

  button_click_event_detector_unit DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .pin_level_i       (pin_level_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .fired_events_o    (fired_events_o),
    .current_event_o   (current_event_o),
    .repeat_count_o    (repeat_count_o),
    .debounced_level_o (debounced_level_o)
  );

  // predictor copy of registers and state
  logic            mdl_active   = bcd_pkg::RstActiveLevel;
  logic [7:0]      mdl_debounce = bcd_pkg::RstDebounceTick;
  logic [15:0]     mdl_short    = bcd_pkg::RstShortTicks;
  logic [15:0]     mdl_long     = bcd_pkg::RstLongTicks;
  press_state_e    mdl_state    = PS_IDLE;
  logic [15:0]     mdl_ticks    = '0;
  logic [7:0]      mdl_db_cnt   = '0;
  logic            mdl_level    = bcd_pkg::RstStableLevel;
  logic [3:0]      mdl_presses  = '0;
  bcd_pkg::event_e mdl_event    = bcd_pkg::EV_NONE;

  // stimulus-side view of the current settings, used to shape gestures
  logic        st_act   = bcd_pkg::RstActiveLevel;
  int unsigned st_db    = bcd_pkg::RstDebounceTick;
  int unsigned st_short = bcd_pkg::RstShortTicks;
  int unsigned st_long  = bcd_pkg::RstLongTicks;

  logic         tick_q[$];
  tick_result_t result_q[$];
  int unsigned  items_queued   = 0;
  int unsigned  results_seen   = 0;
  int unsigned  cfg_writes     = 0;
  int unsigned  errors         = 0;
  int unsigned  n_single       = 0;
  int unsigned  n_double       = 0;
  int unsigned  n_long         = 0;
  int unsigned  send_idle_pct  = 0;
  int unsigned  recv_stall_pct = 0;
  bit           in_taken       = 1'b0;

  // advance debouncer and press machine by one tick
  function automatic tick_result_t predict_tick(input logic pin);
    tick_result_t r;
    logic [6:0]   fire;
    logic         down;
    fire = '0;
    if (mdl_state != PS_IDLE) mdl_ticks = mdl_ticks + 16'd1;
    if (pin != mdl_level) begin
      mdl_db_cnt = mdl_db_cnt + 8'd1;
      if (mdl_db_cnt >= mdl_debounce) begin
        mdl_level  = pin;
        mdl_db_cnt = '0;
      end
    end else begin
      mdl_db_cnt = '0;
    end
    down = (mdl_level == mdl_active);
    case (mdl_state)
      PS_IDLE: begin
        if (down) begin
          mdl_event               = bcd_pkg::EV_DOWN;
          fire[bcd_pkg::FireDown] = 1'b1;
          mdl_ticks               = '0;
          mdl_presses             = 4'd1;
          mdl_state               = PS_PRESSED;
        end else begin
          mdl_event = bcd_pkg::EV_NONE;
        end
      end
      PS_PRESSED: begin
        if (!down) begin
          mdl_event             = bcd_pkg::EV_UP;
          fire[bcd_pkg::FireUp] = 1'b1;
          mdl_ticks             = '0;
          mdl_state             = PS_WAIT;
        end else if (mdl_ticks > mdl_long) begin
          mdl_event                    = bcd_pkg::EV_LONG_START;
          fire[bcd_pkg::FireLongStart] = 1'b1;
          mdl_state                    = PS_LONG;
        end
      end
      PS_WAIT: begin
        if (down) begin
          mdl_event                 = bcd_pkg::EV_DOWN;
          fire[bcd_pkg::FireDown]   = 1'b1;
          fire[bcd_pkg::FireRepeat] = 1'b1;
          if (mdl_presses != bcd_pkg::RepeatLimit) mdl_presses = mdl_presses + 4'd1;
          mdl_ticks = '0;
          mdl_state = PS_REPEAT;
        end else if (mdl_ticks > mdl_short) begin
          // three or more clicks end silently
          if (mdl_presses == 4'd1) begin
            mdl_event                 = bcd_pkg::EV_SINGLE;
            fire[bcd_pkg::FireSingle] = 1'b1;
          end else if (mdl_presses == 4'd2) begin
            mdl_event                 = bcd_pkg::EV_DOUBLE;
            fire[bcd_pkg::FireDouble] = 1'b1;
          end
          mdl_state = PS_IDLE;
        end
      end
      PS_REPEAT: begin
        if (!down) begin
          mdl_event             = bcd_pkg::EV_UP;
          fire[bcd_pkg::FireUp] = 1'b1;
          if (mdl_ticks < mdl_short) begin
            mdl_ticks = '0;
            mdl_state = PS_WAIT;
          end else begin
            mdl_state = PS_IDLE;
          end
        end else if (mdl_ticks > mdl_short) begin
          mdl_state = PS_PRESSED;
        end
      end
      PS_LONG: begin
        if (down) begin
          mdl_event               = bcd_pkg::EV_HOLD;
          fire[bcd_pkg::FireHold] = 1'b1;
        end else begin
          mdl_event             = bcd_pkg::EV_UP;
          fire[bcd_pkg::FireUp] = 1'b1;
          mdl_state             = PS_IDLE;
        end
      end
      default: mdl_state = PS_IDLE;
    endcase
    r.fired   = fire;
    r.evt     = mdl_event;
    r.presses = mdl_presses;
    r.level   = mdl_level;
    return r;
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // tick sender and result receiver, driven on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          pin_level_i <= tick_q.pop_front();
          in_valid_i  <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: register writes, tick transfers and result checks
  always @(posedge clk_i) begin
    tick_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (result_q.size() == 0) begin
          $error("result transfer with no tick outstanding");
          errors++;
        end else begin
          want = result_q.pop_front();
          if (fired_events_o !== want.fired) begin
            $error("fired_events: expected %0h, actual %0h", want.fired, fired_events_o);
            errors++;
          end
          if (current_event_o !== want.evt) begin
            $error("current_event: expected %0d, actual %0d", want.evt, current_event_o);
            errors++;
          end
          if (repeat_count_o !== want.presses) begin
            $error("repeat_count: expected %0d, actual %0d", want.presses, repeat_count_o);
            errors++;
          end
          if (debounced_level_o !== want.level) begin
            $error("debounced_level: expected %0b, actual %0b", want.level,
                   debounced_level_o);
            errors++;
          end
          if (want.fired[bcd_pkg::FireSingle]) n_single++;
          if (want.fired[bcd_pkg::FireDouble]) n_double++;
          if (want.fired[bcd_pkg::FireLongStart]) n_long++;
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_writes++;
        case (cfg_index_i)
          bcd_pkg::CfgActiveLevel:  mdl_active   = cfg_data_i[0];
          bcd_pkg::CfgDebounceTick: mdl_debounce = cfg_data_i[7:0];
          bcd_pkg::CfgShortTicks:   mdl_short    = cfg_data_i;
          bcd_pkg::CfgLongTicks:    mdl_long     = cfg_data_i;
          default: ;
        endcase
      end
      in_taken = in_valid_i && in_ready_o;
      if (in_taken) result_q.push_back(predict_tick(pin_level_i));
    end
  end

  task automatic push_level(input logic lvl, input int unsigned n);
    repeat (n) tick_q.push_back(lvl);
    items_queued += n;
  endtask

  // stimulus holds off until every queued tick has its result
  task automatic wait_drained();
    while (results_seen < items_queued) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(input logic act, input logic [15:0] db,
                            input logic [15:0] s, input logic [15:0] l);
    wait_drained();
    write_reg(bcd_pkg::CfgActiveLevel, {15'd0, act});
    write_reg(bcd_pkg::CfgDebounceTick, db);
    write_reg(bcd_pkg::CfgShortTicks, s);
    write_reg(bcd_pkg::CfgLongTicks, l);
    st_act   = act;
    st_db    = db[7:0];
    st_short = s;
    st_long  = l;
  endtask

  // one random gesture, sized from the current settings
  task automatic add_gesture();
    int unsigned settle;
    logic        on;
    on     = st_act;
    settle = st_db + 1;
    case ($urandom_range(9))
      0, 1: begin
        // single click
        push_level(on, settle + $urandom_range(st_short / 2 + 1, 1));
        push_level(!on, settle + st_short + $urandom_range(6, 2));
      end
      2, 3: begin
        // quick multi-click, then let the window run out
        repeat ($urandom_range(4, 2)) begin
          push_level(on, settle + $urandom_range(st_short / 2, 1));
          push_level(!on, settle + $urandom_range(st_short / 2, 1));
        end
        push_level(!on, st_short + 4);
      end
      4: begin
        // long press with a few hold ticks
        push_level(on, settle + st_long + $urandom_range(6, 1));
        push_level(!on, settle + $urandom_range(4, 1));
      end
      5, 6: begin
        // irregular presses around both limits
        repeat ($urandom_range(3, 1)) begin
          push_level(on, $urandom_range(st_long + settle + 2, 1));
          push_level(!on, $urandom_range(st_short + settle + 2, 1));
        end
      end
      7: begin
        // pulse that may be shorter than the debounce time
        push_level(on, $urandom_range(settle, 1));
        push_level(!on, settle + 1);
      end
      8: repeat ($urandom_range(12, 1)) push_level(1'($urandom_range(1, 0)), 1);
      default: push_level(!on, $urandom_range(8, 1));
    endcase
  endtask

  // stimulus
  initial begin
    int unsigned mark;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: released, glitch, press, release, press
    push_level(1'b1, 3);
    push_level(1'b0, 2);
    push_level(1'b1, 1);
    push_level(1'b0, 6);
    push_level(1'b1, 5);
    push_level(1'b0, 8);

    // active-high button with instant debounce: reads pressed right away
    set_config(1'b1, 16'd0, 16'd3, 16'd5);
    write_reg(8'd4, 16'hFFFF);
    write_reg(8'hFF, 16'hFFFF);
    write_reg(8'h80, 16'h5555);
    push_level(1'b1, 3);
    push_level(1'b0, 8);
    // double click
    push_level(1'b1, 2);
    push_level(1'b0, 2);
    push_level(1'b1, 2);
    push_level(1'b0, 8);
    // triple click ends with no click event
    repeat (3) begin
      push_level(1'b1, 2);
      push_level(1'b0, 2);
    end
    push_level(1'b0, 6);
    // second press held past the short limit
    push_level(1'b1, 2);
    push_level(1'b0, 2);
    push_level(1'b1, 6);
    push_level(1'b0, 8);
    // second press released exactly at the short limit
    push_level(1'b1, 2);
    push_level(1'b0, 2);
    push_level(1'b1, 3);
    push_level(1'b0, 6);
    // long press and hold
    push_level(1'b1, 12);
    push_level(1'b0, 6);

    // press count saturation
    set_config(1'b0, 16'd1, 16'd8, 16'd30);
    push_level(1'b1, 4);
    repeat (17) begin
      push_level(1'b0, 3);
      push_level(1'b1, 3);
    end
    push_level(1'b1, 20);

    // widest debounce (upper data bits ignored), tightest limits
    set_config(1'b0, 16'hA5FF, 16'd1, 16'd1);
    push_level(1'b0, 260);
    push_level(1'b1, 20);

    // widest limits: no timeout fires and no long press starts
    set_config(1'b1, 16'd2, 16'hFFFF, 16'hFFFF);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    push_level(1'b1, 40);
    push_level(1'b0, 20);
    push_level(1'b1, 10);
    push_level(1'b0, 30);

    // random gestures under each idling pattern
    for (int mode = 0; mode < 4; mode++) begin
      repeat (2) begin
        set_config(1'($urandom_range(1, 0)), 16'($urandom_range(4, 0)),
                   16'($urandom_range(20, 3)), 16'($urandom_range(40, 4)));
        case (mode)
          0: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
          end
          1: begin
            send_idle_pct  = 59;
            recv_stall_pct = 0;
          end
          2: begin
            send_idle_pct  = 0;
            recv_stall_pct = 59;
          end
          default: begin
            send_idle_pct  = 24;
            recv_stall_pct = 24;
          end
        endcase
        mark = items_queued;
        while (items_queued - mark < 15) add_gesture();
        wait_drained();
        while (items_queued - mark < 30) add_gesture();
      end
    end

    // back to reset-like settings for a last burst
    set_config(bcd_pkg::RstActiveLevel, {8'd0, bcd_pkg::RstDebounceTick}, 16'd10, 16'd20);
    repeat (3) add_gesture();

    wait_drained();
    repeat (5) @(negedge clk_i);
    if (result_q.size() != 0) begin
      $error("%0d expected results never arrived", result_q.size());
      errors++;
    end
    $display("checked %0d tick results across %0d register writes", results_seen,
             cfg_writes);
    $display("events seen: %0d single clicks, %0d double clicks, %0d long presses",
             n_single, n_double, n_long);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: button_click_event_detector_unit.f
+incdir+design
design/bcd_pkg.sv
design/bcd_debounce.sv
design/bcd_press_fsm.sv
design/button_click_event_detector_unit.sv
dv/button_click_event_detector_unit_tb.sv
